@@ rtl/text_console_cell_engine_defines.svh @@
// assertion macros for the text console cell engine
// no dependencies; included by the top level
`ifndef TEXT_CONSOLE_CELL_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CELL_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tce check failed");
`define TCE_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tce check failed");
`else
`define TCE_ASSERT(name, prop)
`define TCE_ASSERT_IMPL(name, pre, post)
`endif
`endif

@@ rtl/tce_pkg.sv @@
// shared types and constants of the text console cell engine
// no dependencies
package tce_pkg;

  localparam int CELL_W = 16;

  localparam logic [2:0] OP_PUTC    = 3'd0;
  localparam logic [2:0] OP_CHATTR  = 3'd1;
  localparam logic [2:0] OP_SETATTR = 3'd2;
  localparam logic [2:0] OP_SETCHAR = 3'd3;
  localparam logic [2:0] OP_SETCUR  = 3'd4;
  localparam logic [2:0] OP_GETCUR  = 3'd5;
  localparam logic [2:0] OP_FLUSH   = 3'd6;
  localparam logic [2:0] OP_NOP     = 3'd7;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CELL   = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef struct packed {
    logic signed [8:0] left;
    logic signed [6:0] top;
    logic signed [8:0] right;
    logic signed [6:0] bottom;
  } box_t;

  typedef struct packed {
    logic mark;
    logic fill;
    logic clear;
  } box_ctrl_t;

endpackage

@@ rtl/text_console_cell_engine.sv @@
// text console cell engine: control sequencer, cursor, attribute and output register
// depends on tce_pkg, tce_cell_ram, tce_dirty_box and the defines header
// results are registered; a new request is taken only when the one before is done
// a tab gives up to TAB_STOP cell results, one per cycle while the output is free
// a scroll moves rows up and blanks the bottom row, one cell a cycle, and holds off requests
// reset: a clearing pass zeroes every cell of the store; no request is taken meanwhile
`include "text_console_cell_engine_defines.svh"
module text_console_cell_engine import tce_pkg::*; #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // char_code, attr_in, col_in, row_in, zero fill
  input  logic [2:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // cell_row, cell_col, cell_char, cell_attr,
                                     // cursor_col, cursor_row, dirty_left, dirty_top,
                                     // dirty_right, dirty_bottom, zero fill
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast
);

  localparam int TOTAL  = COLS * ROWS;
  localparam int AW     = $clog2(TOTAL);
  localparam int NSTOPS = 128 / TAB_STOP + 1;
  localparam logic [AW-1:0] COLS_A   = AW'(COLS);
  localparam logic [AW-1:0] LAST_A   = AW'(TOTAL - 1);
  localparam logic [AW-1:0] BOTTOM_A = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] ONE_A    = AW'(1);
  localparam logic [6:0]    COL_MAX  = 7'(COLS - 1);
  localparam logic [4:0]    ROW_MAX  = 5'(ROWS - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_STATUS = 3'd2;
  localparam logic [2:0] ST_REPORT = 3'd3;
  localparam logic [2:0] ST_PUT    = 3'd4;
  localparam logic [2:0] ST_RMW    = 3'd5;
  localparam logic [2:0] ST_SCROLL = 3'd6;

  function automatic logic [AW-1:0] cell_addr(input logic [6:0] c, input logic [4:0] r);
    cell_addr = AW'(r) * COLS_A + AW'(c);
  endfunction

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [6:0]    cursor_col, cursor_col_next;
  logic [4:0]    cursor_row, cursor_row_next;
  logic [7:0]    cur_attr, cur_attr_next;
  logic [2:0]    req_op, req_op_next;
  logic [7:0]    req_char, req_char_next;
  logic [7:0]    req_attr, req_attr_next;
  logic [6:0]    req_col, req_col_next;
  logic [4:0]    req_row, req_row_next;
  logic [7:0]    put_char, put_char_next;
  logic          put_tab, put_tab_next;
  logic [AW-1:0] scr_addr, scr_addr_next;
  logic          scr_blank, scr_blank_next;
  logic          scr_done, scr_done_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic          pend_blank, pend_blank_next;

  logic              ram_wr_en, ram_rd_en;
  logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
  logic [CELL_W-1:0] ram_wr_data, ram_rd_data;

  box_ctrl_t  box_ctrl;
  logic [6:0] pt_col;
  logic [4:0] pt_row;
  box_t       box, box_next, e_box;

  logic       accept, out_free, at_stop;
  logic [6:0] col_inc;
  logic [2:0] in_op;
  logic [7:0] in_char, in_attr;
  logic [6:0] in_col;
  logic [4:0] in_row;
  logic [CELL_W-1:0] rmw_data;

  logic       emit, e_report, e_last;
  logic [1:0] e_kind;
  logic [4:0] e_cell_row, e_cur_row;
  logic [6:0] e_cell_col, e_cur_col;
  logic [7:0] e_cell_char, e_cell_attr;

  assign in_op   = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_attr = s_axis_tdata[15:8];
  assign in_col  = s_axis_tdata[22:16];
  assign in_row  = s_axis_tdata[27:23];

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign col_inc       = cursor_col + 7'd1;

  // tab stop test on the advanced column
  always_comb begin
    at_stop = 1'b0;
    for (int k = 0; k < NSTOPS; k++) begin
      if (k * TAB_STOP == int'(col_inc)) at_stop = 1'b1;
    end
  end

  assign rmw_data = (req_op == OP_SETATTR) ? {req_attr, ram_rd_data[7:0]}
                                           : {ram_rd_data[15:8], req_char};

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    cur_attr_next   = cur_attr;
    req_op_next     = req_op;
    req_char_next   = req_char;
    req_attr_next   = req_attr;
    req_col_next    = req_col;
    req_row_next    = req_row;
    put_char_next   = put_char;
    put_tab_next    = put_tab;
    scr_addr_next   = scr_addr;
    scr_blank_next  = scr_blank;
    scr_done_next   = scr_done;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    pend_blank_next = pend_blank;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = cell_addr(in_col, in_row);
    box_ctrl    = '0;
    pt_col      = cursor_col;
    pt_row      = cursor_row;
    emit        = 1'b0;
    e_report    = 1'b0;
    e_last      = 1'b1;
    e_kind      = KIND_STATUS;
    e_cell_row  = '0;
    e_cell_col  = '0;
    e_cell_char = '0;
    e_cell_attr = '0;
    e_cur_col   = cursor_col;
    e_cur_row   = cursor_row;

    unique case (state)
      ST_CLEAR: begin
        ram_wr_en     = 1'b1;
        ram_wr_addr   = clr_addr;
        clr_addr_next = clr_addr + ONE_A;
        if (clr_addr == LAST_A) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          req_op_next   = in_op;
          req_char_next = in_char;
          req_attr_next = in_attr;
          req_col_next  = in_col;
          req_row_next  = in_row;
          state_next    = ST_STATUS;
          case (in_op)
            OP_PUTC: begin
              if (in_char == CH_NL) begin
                cursor_col_next = '0;
                if (cursor_row != ROW_MAX) begin
                  cursor_row_next = cursor_row + 5'd1;
                end else begin
                  state_next     = ST_SCROLL;
                  scr_addr_next  = COLS_A;
                  scr_blank_next = 1'b0;
                  scr_done_next  = 1'b0;
                  pend_next      = 1'b0;
                end
              end else if (in_char == CH_BS) begin
                if (cursor_col == '0 && cursor_row != '0) begin
                  cursor_row_next = cursor_row - 5'd1;
                  cursor_col_next = COL_MAX;
                end else if (cursor_col != '0) begin
                  cursor_col_next = cursor_col - 7'd1;
                end
              end else begin
                put_tab_next  = (in_char == CH_TAB);
                put_char_next = (in_char == CH_TAB) ? CH_SPACE : in_char;
                state_next    = ST_PUT;
              end
            end
            OP_CHATTR: cur_attr_next = in_attr;
            OP_SETATTR, OP_SETCHAR: begin
              if (int'(in_col) < COLS && int'(in_row) < ROWS) begin
                ram_rd_en  = 1'b1;
                state_next = ST_RMW;
              end
            end
            OP_SETCUR: begin
              cursor_col_next = (int'(in_col) < COLS) ? in_col : COL_MAX;
              cursor_row_next = (int'(in_row) < ROWS) ? in_row : ROW_MAX;
            end
            OP_FLUSH: state_next = ST_REPORT;
            OP_GETCUR, OP_NOP: state_next = ST_STATUS;
            default: state_next = ST_STATUS;
          endcase
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit           = 1'b1;
          e_report       = 1'b1;
          e_kind         = KIND_REPORT;
          box_ctrl.clear = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_PUT: begin
        if (out_free) begin
          ram_wr_en     = 1'b1;
          ram_wr_addr   = cell_addr(cursor_col, cursor_row);
          ram_wr_data   = {cur_attr, put_char};
          box_ctrl.mark = 1'b1;
          emit          = 1'b1;
          e_kind        = KIND_CELL;
          e_cell_row    = cursor_row;
          e_cell_col    = cursor_col;
          e_cell_char   = put_char;
          e_cell_attr   = cur_attr;
          if (cursor_col != COL_MAX) begin
            cursor_col_next = col_inc;
            e_cur_col       = col_inc;
            e_last          = !(put_tab && !at_stop);
            state_next      = e_last ? ST_IDLE : ST_PUT;
          end else begin
            cursor_col_next = '0;
            if (cursor_row != ROW_MAX) begin
              cursor_row_next = cursor_row + 5'd1;
              e_cur_col       = '0;
              e_cur_row       = cursor_row + 5'd1;
              state_next      = ST_IDLE;
            end else begin
              // wrap on the last row: the scroll result closes the request
              e_last         = 1'b0;
              state_next     = ST_SCROLL;
              scr_addr_next  = COLS_A;
              scr_blank_next = 1'b0;
              scr_done_next  = 1'b0;
              pend_next      = 1'b0;
            end
          end
        end
      end
      ST_RMW: begin
        pt_col = req_col;
        pt_row = req_row;
        if (out_free) begin
          ram_wr_en     = 1'b1;
          ram_wr_addr   = cell_addr(req_col, req_row);
          ram_wr_data   = rmw_data;
          box_ctrl.mark = 1'b1;
          emit          = 1'b1;
          e_kind        = KIND_CELL;
          e_cell_row    = req_row;
          e_cell_col    = req_col;
          e_cell_char   = rmw_data[7:0];
          e_cell_attr   = rmw_data[15:8];
          state_next    = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        // rows move up one, then the bottom row gets blank characters
        if (pend) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = pend_addr;
          ram_wr_data = pend_blank ? {ram_rd_data[15:8], CH_SPACE} : ram_rd_data;
        end
        if (!scr_done) begin
          ram_rd_en       = 1'b1;
          ram_rd_addr     = scr_addr;
          pend_next       = 1'b1;
          pend_addr_next  = scr_blank ? scr_addr : scr_addr - COLS_A;
          pend_blank_next = scr_blank;
          if (scr_addr == LAST_A) begin
            if (!scr_blank) begin
              scr_blank_next = 1'b1;
              scr_addr_next  = BOTTOM_A;
            end else begin
              scr_done_next = 1'b1;
            end
          end else begin
            scr_addr_next = scr_addr + ONE_A;
          end
        end else begin
          pend_next = 1'b0;
          if (!pend && out_free) begin
            box_ctrl.fill = 1'b1;
            emit          = 1'b1;
            e_kind        = KIND_SCROLL;
            state_next    = ST_IDLE;
          end
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign e_box = e_report ? box : box_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
      cur_attr   <= ATTR_RESET;
      scr_done   <= 1'b0;
      pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      cur_attr   <= cur_attr_next;
      scr_done   <= scr_done_next;
      pend       <= pend_next;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_op     <= req_op_next;
    req_char   <= req_char_next;
    req_attr   <= req_attr_next;
    req_col    <= req_col_next;
    req_row    <= req_row_next;
    put_char   <= put_char_next;
    put_tab    <= put_tab_next;
    scr_addr   <= scr_addr_next;
    scr_blank  <= scr_blank_next;
    pend_addr  <= pend_addr_next;
    pend_blank <= pend_blank_next;
    if (emit) begin
      m_axis_tuser <= e_kind;
      m_axis_tlast <= e_last;
      m_axis_tdata <= {4'b0000, e_box.bottom[5:0], e_box.right[7:0], e_box.top[5:0],
                       e_box.left[7:0], e_cur_row, e_cur_col, e_cell_attr,
                       e_cell_char, e_cell_col, e_cell_row};
    end
  end

  tce_cell_ram #(
    .DEPTH(TOTAL),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  tce_dirty_box #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_dirty (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (box_ctrl),
    .pt_col  (pt_col),
    .pt_row  (pt_row),
    .box     (box),
    .box_next(box_next)
  );

  `TCE_ASSERT(a_cursor_on_screen, int'(cursor_col) < COLS && int'(cursor_row) < ROWS)
  `TCE_ASSERT(a_box_sane, box.left == -9'sd1 || (box.left < box.right && box.top < box.bottom))
  `TCE_ASSERT_IMPL(a_scroll_no_overlap, state == ST_SCROLL && !scr_done && pend, pend_addr != scr_addr)
  `TCE_ASSERT_IMPL(a_store_idle_quiet, state == ST_IDLE, !ram_wr_en)

endmodule

@@ rtl/tce_cell_ram.sv @@
// cell store: one write port, one read port with registered read data
// depends on tce_pkg
module tce_cell_ram import tce_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [CELL_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [CELL_W-1:0] rd_data
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/tce_dirty_box.sv @@
// dirty rectangle register with point merge, fill and clear
// depends on tce_pkg
module tce_dirty_box import tce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic      clk,
  input  logic      rst,
  input  box_ctrl_t ctrl,
  input  logic [6:0] pt_col,
  input  logic [4:0] pt_row,
  output box_t      box,
  output box_t      box_next
);

  logic signed [8:0] pc;
  logic signed [8:0] pc1;
  logic signed [6:0] pr;
  logic signed [6:0] pr1;
  box_t              marked;

  assign pc  = signed'({2'b00, pt_col});
  assign pc1 = pc + 9'sd1;
  assign pr  = signed'({2'b00, pt_row});
  assign pr1 = pr + 7'sd1;

  always_comb begin
    marked = box;
    if (box.left == -9'sd1) begin
      marked = '{left: pc, top: pr, right: pc1, bottom: pr1};
    end else begin
      if (pc < box.left) marked.left = pc;
      if (pr < box.top) marked.top = pr;
      if (pc1 > box.right) marked.right = pc1;
      if (pr1 > box.bottom) marked.bottom = pr1;
    end
  end

  always_comb begin
    box_next = box;
    if (ctrl.clear) begin
      box_next = '{left: -9'sd1, top: -7'sd1, right: -9'sd1, bottom: -7'sd1};
    end else if (ctrl.fill) begin
      box_next = '{left: 9'sd0, top: 7'sd0, right: 9'(COLS), bottom: 7'(ROWS)};
    end else if (ctrl.mark) begin
      box_next = marked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '{left: -9'sd1, top: -7'sd1, right: -9'sd1, bottom: -7'sd1};
    end else begin
      box <= box_next;
    end
  end

endmodule
